FILE: rtl/semtbl_pkg.sv
`default_nettype none

package semtbl_pkg;

    // Request kinds carried on s_tuser
    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_UP     = 2'd1;
    localparam logic [1:0] OP_DOWN   = 2'd2;
    localparam logic [1:0] OP_BAD    = 2'd3;

    // Result status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_NOSEM    = 3'd1;
    localparam logic [2:0] STS_NOTOWNER = 3'd2;
    localparam logic [2:0] STS_BLOCKED  = 3'd3;
    localparam logic [2:0] STS_TFULL    = 3'd4;
    localparam logic [2:0] STS_QFULL    = 3'd5;
    localparam logic [2:0] STS_SAT      = 3'd6;

    // Beat widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

endpackage

`default_nettype wire

FILE: rtl/semaphore_table_with_wait_queues.sv
`default_nettype none
// Hardware counting-semaphore table with a FIFO of waiting process ids per semaphore.
// Input channel (s_*): one request per beat; s_tuser carries the request kind
// (create, up, down), s_tdata the semaphore index, the starting count and the pid.
// Result channel (m_*): exactly one result beat per request, in request order,
// carrying status, allocated id and the pid released by an up.
// Flow: requests are taken one at a time in the idle state and resolved in the look
// state, so create, down, failed requests and an up with an empty queue end there;
// an up that releases a waiter also passes the pop state, because the queue head is
// only known after the per-slot read and the wait-queue memory needs a second read.
// Per-slot state (count, owner, queue head and fill) sits in one synchronous memory,
// the waiting pids in a second one; both are read synchronously into registers.
// Reset clears the per-slot valid bits at once; no clearing pass is needed since a
// create writes every per-slot field before use.
// Result stall: the output register holds a finished result while the next request
// is accepted; it then waits in its resolve or pop step until the register frees.
module semaphore_table_with_wait_queues #(
    parameter int NUM_SEMS    = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int PID_BITS    = 8,
    parameter int COUNT_BITS  = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // [3:0] sem_index, [19:4] init_value, [27:20] pid, [31:28] zero
    input  wire  [semtbl_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] operation
    input  wire  [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [2:0] status, [6:3] new_id, [7] woken_valid, [15:8] woken_pid
    output logic [semtbl_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int SW  = $clog2(NUM_SEMS);
    localparam int IXW = (SW > 4) ? SW : 4;
    localparam int PW  = (PID_BITS < 8) ? PID_BITS : 8;
    localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int QAW = $clog2(NUM_SEMS * QUEUE_DEPTH);
    localparam int CW  = COUNT_BITS;

    localparam logic signed [32:0] SAT_HI = 33'((33'sd1 <<< (CW - 1)) - 33'sd1);
    localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;
    localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW - 1){1'b1}}};

    typedef struct packed {
        logic signed [CW-1:0] count;
        logic                 owner_set;
        logic [PW-1:0]        owner_pid;
        logic [HW-1:0]        head;
        logic [FW-1:0]        fill;
    } slot_t;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_POP} state_t;

    // Storage
    slot_t         slot_mem [NUM_SEMS];
    logic [PW-1:0] wait_mem [NUM_SEMS * QUEUE_DEPTH];

    state_t                          state_reg;
    logic [NUM_SEMS-1:0]             valid_reg;
    logic [SW-1:0]                   free_idx_reg;
    logic                            free_any_reg;
    logic [1:0]                      op_reg;
    logic [SW-1:0]                   idx_reg;
    logic                            in_range_reg;
    logic signed [CW-1:0]            init_reg;
    logic [PW-1:0]                   pid_reg;
    logic [2:0]                      pop_status_reg;
    slot_t                           slot_rd_reg;
    logic [PW-1:0]                   wait_rd_reg;
    logic                            m_tvalid_reg;
    logic [semtbl_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // Decode of the incoming beat
    logic [IXW-1:0]       in_idx;
    logic                 in_range;
    logic signed [32:0]   init_ext;
    logic signed [32:0]   init_sat;
    logic                 accept;

    // Resolve step
    logic                 out_free;
    logic                 out_load;
    logic                 slot_ok;
    logic [SW-1:0]        free_idx_next;
    logic                 free_any_next;
    logic [2:0]           status;
    logic [3:0]           new_id;
    logic                 slot_we;
    logic [SW-1:0]        slot_wa;
    slot_t                slot_wd;
    logic                 wait_we;
    logic                 wait_re;
    logic [QAW-1:0]       q_base;
    logic [HW:0]          tail_sum;
    logic [HW-1:0]        tail;
    logic [HW-1:0]        head_inc;
    logic                 go_pop;
    logic                 look_done;
    logic                 set_valid;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_idx   = IXW'(s_tdata[3:0]);
    assign in_range = {1'b0, in_idx} < (IXW + 1)'(NUM_SEMS);
    assign init_ext = {{17{s_tdata[19]}}, s_tdata[19:4]};

    always_comb begin
        init_sat = init_ext;
        if (init_ext > SAT_HI) begin
            init_sat = SAT_HI;
        end else if (init_ext < SAT_LO) begin
            init_sat = SAT_LO;
        end
    end

    // Lowest free slot, registered and refreshed every cycle
    always_comb begin
        free_idx_next = '0;
        free_any_next = 1'b0;
        for (int i = NUM_SEMS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx_next = SW'(i);
                free_any_next = 1'b1;
            end
        end
    end

    assign slot_ok  = in_range_reg && valid_reg[idx_reg];
    assign q_base   = QAW'(idx_reg) * QAW'(QUEUE_DEPTH);
    assign tail_sum = (HW + 1)'(slot_rd_reg.head) + (HW + 1)'(slot_rd_reg.fill);
    assign tail     = (tail_sum >= (HW + 1)'(QUEUE_DEPTH))
                    ? HW'(tail_sum - (HW + 1)'(QUEUE_DEPTH)) : HW'(tail_sum);
    assign head_inc = (slot_rd_reg.head == HW'(QUEUE_DEPTH - 1))
                    ? '0 : slot_rd_reg.head + HW'(1);

    // Read-modify-write of one slot entry
    always_comb begin
        status    = semtbl_pkg::STS_OK;
        new_id    = '0;
        slot_we   = 1'b0;
        slot_wa   = idx_reg;
        slot_wd   = slot_rd_reg;
        wait_we   = 1'b0;
        go_pop    = 1'b0;
        set_valid = 1'b0;
        if (op_reg == semtbl_pkg::OP_CREATE) begin
            if (free_any_reg) begin
                slot_we           = 1'b1;
                slot_wa           = free_idx_reg;
                slot_wd.count     = init_reg;
                slot_wd.owner_set = 1'b0;
                slot_wd.owner_pid = '0;
                slot_wd.head      = '0;
                slot_wd.fill      = '0;
                set_valid         = 1'b1;
                new_id            = 4'(free_idx_reg);
            end else begin
                status = semtbl_pkg::STS_TFULL;
            end
        end else if (op_reg == semtbl_pkg::OP_BAD || !slot_ok) begin
            status = semtbl_pkg::STS_NOSEM;
        end else if (op_reg == semtbl_pkg::OP_UP) begin
            slot_we = 1'b1;
            if (slot_rd_reg.count == CNT_MAX) begin
                status = semtbl_pkg::STS_SAT;
            end else begin
                slot_wd.count = slot_rd_reg.count + CW'(1);
            end
            if (slot_rd_reg.fill != '0) begin
                go_pop       = 1'b1;
                slot_wd.head = head_inc;
                slot_wd.fill = slot_rd_reg.fill - FW'(1);
            end
        end else begin
            if (slot_rd_reg.owner_set && slot_rd_reg.owner_pid != pid_reg) begin
                status = semtbl_pkg::STS_NOTOWNER;
            end else begin
                slot_we           = 1'b1;
                slot_wd.owner_set = 1'b1;
                if (!slot_rd_reg.owner_set) begin
                    slot_wd.owner_pid = pid_reg;
                end
                if (slot_rd_reg.count > 0) begin
                    slot_wd.count = slot_rd_reg.count - CW'(1);
                end else if (slot_rd_reg.fill == FW'(QUEUE_DEPTH)) begin
                    status = semtbl_pkg::STS_QFULL;
                end else begin
                    wait_we      = 1'b1;
                    slot_wd.fill = slot_rd_reg.fill + FW'(1);
                    status       = semtbl_pkg::STS_BLOCKED;
                end
            end
        end
    end

    // A pop moves on without the output register; everything else waits for it
    assign look_done = (state_reg == S_LOOK) && (go_pop || out_free);
    assign wait_re   = look_done && go_pop;
    // Load the output register with a finished result
    assign out_load  = (look_done && !go_pop) || ((state_reg == S_POP) && out_free);

    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_rd_reg <= slot_mem[in_idx[SW-1:0]];
        end
        if (look_done && slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (wait_re) begin
            wait_rd_reg <= wait_mem[q_base + QAW'(slot_rd_reg.head)];
        end
        if (look_done && wait_we) begin
            wait_mem[q_base + QAW'(tail)] <= pid_reg;
        end
    end

    // Hold the request fields for the resolve step
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= s_tuser;
            idx_reg      <= in_idx[SW-1:0];
            in_range_reg <= in_range;
            init_reg     <= CW'(init_sat);
            pid_reg      <= s_tdata[20 +: PW];
        end
        if (wait_re) begin
            pop_status_reg <= status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            free_idx_reg <= '0;
            free_any_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else begin
            free_idx_reg <= free_idx_next;
            free_any_reg <= free_any_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (look_done) begin
                        if (set_valid) begin
                            valid_reg[free_idx_reg] <= 1'b1;
                        end
                        if (go_pop) begin
                            state_reg <= S_POP;
                        end else begin
                            state_reg   <= S_IDLE;
                            m_tdata_reg <= {8'd0, 1'b0, new_id, status};
                        end
                    end
                end
                S_POP: begin
                    if (out_free) begin
                        state_reg   <= S_IDLE;
                        m_tdata_reg <= {8'(wait_rd_reg), 1'b1, 4'd0, pop_status_reg};
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
